// ===== rtl/blsa_pkg.sv =====
// ----------------------------------------------------------------------------
// blsa_pkg: shared definitions for the binary logarithm shift-add block
// Widths, status and register codes, control types, and the constant table
// of log2(1 + 2^-(k+1)) entries used by the shift-add steps.
// ----------------------------------------------------------------------------
`default_nettype none

package blsa_pkg;

	// Field and datapath widths.
	localparam int X_W           = 64;
	localparam int LOG_W         = 38;
	localparam int STAT_W        = 2;
	localparam int ITER_W        = 6;
	localparam int FRAC_BITS     = 32;
	localparam int IN_FRAC       = 32;
	localparam int TABLE_ENTRIES = 32;
	localparam int MANT_POS      = 62;
	localparam int MANT_W        = MANT_POS + 1;
	localparam int POS_W         = $clog2(MANT_W);
	localparam int YY_W          = FRAC_BITS + 1;
	localparam int CHAR_W        = LOG_W - FRAC_BITS;
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
	localparam int K_W           = $clog2(TABLE_ENTRIES);
	localparam int NORM_STEPS    = $clog2(MANT_W);
	localparam int SHIFT_W       = $clog2(MANT_W + 1);

	// APB port.
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 2;

	// Register map.
	localparam logic [APB_ADDR_W-1:0] REG_ITERATIONS = '0;
	localparam logic [ITER_W-1:0]     ITER_RESET     = ITER_W'(32);

	// Reciprocal of ln 2 in Q1.63.
	localparam logic [63:0] INV_LN2_Q63 = 64'hB8AA3B295C17F0BC;

	// Result status codes.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_UNDEF   = 2'd1,
		STAT_NEG_INF = 2'd2
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_STEP,
		S_FIN,
		S_OUT
	} state_t;

	// Control from the sequencer to the datapath.
	typedef struct packed {
		logic             load;
		logic             norm;
		logic             step;
		logic             fin;
		logic [CNT_W-1:0] idx;
	} ctrl_t;

	typedef logic [FRAC_BITS-1:0] log_table_t [TABLE_ENTRIES];

	// Floor of 2^m / d by long division, evaluated at elaboration.
	function automatic logic [63:0] pow2_div(input int unsigned m, input int unsigned d);
		logic [64:0] r;
		logic [63:0] q;
		logic [63:0] num;
		int          b;
		r   = '0;
		q   = '0;
		num = 64'd1 << m;
		for (b = 63; b >= 0; b--) begin
			r = {r[63:0], num[b]};
			if (r >= 65'(d)) begin
				r    = r - 65'(d);
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// log2(1 + 2^-n) with 64 fraction bits, from the ln(1+u) series.
	function automatic logic [63:0] log2_one_plus(input int unsigned n);
		logic [63:0]  ln;
		logic [63:0]  t;
		logic [127:0] prod;
		int unsigned  j;
		ln = '0;
		for (j = 1; n * j < 64; j++) begin
			t = pow2_div(64 - n * j, j);
			if (j[0])
				ln = ln + t;
			else
				ln = ln - t;
		end
		prod = 128'(ln) * 128'(INV_LN2_Q63);
		return prod[126:63];
	endfunction

	// Table entries rounded half up to FRAC_BITS fraction bits.
	function automatic log_table_t build_log_table();
		log_table_t  tab;
		logic [63:0] v;
		logic [63:0] r;
		int          k;
		for (k = 0; k < TABLE_ENTRIES; k++) begin
			v      = log2_one_plus(k + 1);
			r      = ((v >> (63 - FRAC_BITS)) + 64'd1) >> 1;
			tab[k] = r[FRAC_BITS-1:0];
		end
		return tab;
	endfunction

	localparam log_table_t LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

// ===== rtl/blsa_if.sv =====
// ----------------------------------------------------------------------------
// blsa_if: item channels of the binary logarithm block
// Valid/ready channels for the operand item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface blsa_in_if;
	logic                              valid;
	logic                              ready;
	logic signed [blsa_pkg::X_W-1:0]   x_value;

	modport source (output valid, output x_value, input ready);
	modport sink   (input valid, input x_value, output ready);
endinterface

interface blsa_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [blsa_pkg::LOG_W-1:0]  log_value;
	logic        [blsa_pkg::STAT_W-1:0] status;

	modport source (output valid, output log_value, output status, input ready);
	modport sink   (input valid, input log_value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/binary_log_shift_add_top.sv =====
// ----------------------------------------------------------------------------
// binary_log_shift_add_top: base-2 logarithm by shift and add
// Top level: configuration port, sequencer and datapath.
// ----------------------------------------------------------------------------
// The block takes one signed Q31.32 operand item at a time and returns
// log2 of it with 32 fraction bits, or a status of undefined for a negative
// operand and minus infinity for zero. A positive operand is accepted, then
// normalized by a binary leading-one search, then refined by one shared
// shift-add-compare unit, with the step count capped at 32, and the result
// is then formed and presented on the output. A negative or zero operand
// yields its result the cycle after acceptance. The shift-add loop sets the
// rate: the block takes no new item until the result has been taken, and is
// ready again the cycle after.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_log_shift_add_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [blsa_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [blsa_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [blsa_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	blsa_in_if.sink                              in_ch,
	blsa_out_if.source                           out_ch
);
	import blsa_pkg::*;

	logic [ITER_W-1:0] iterations;
	logic              special;
	ctrl_t             ctrl;

	// Configuration registers.
	blsa_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.iterations (iterations)
	);

	// Sequencer.
	blsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.iterations (iterations),
		.special    (special),
		.ctrl       (ctrl)
	);

	// Datapath.
	blsa_dp u_dp (
		.clk       (clk),
		.ctrl      (ctrl),
		.x_value   (in_ch.x_value),
		.special   (special),
		.log_value (out_ch.log_value),
		.status    (out_ch.status)
	);

`ifndef SYNTHESIS
	// One item at a time: never ready for input while a result is shown.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("input ready while a result is pending");

	// After an item is accepted the block stays busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("ready again right after an accepted item");

	// Special results carry a zero logarithm.
	a_special_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && (out_ch.status == STAT_UNDEF || out_ch.status == STAT_NEG_INF))
		|-> (out_ch.log_value == '0))
		else $error("special status with nonzero logarithm");
`endif

endmodule

`default_nettype wire

// ===== rtl/blsa_apb_regs.sv =====
// ----------------------------------------------------------------------------
// blsa_apb_regs: configuration register file
// Holds the iteration count register behind an APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module blsa_apb_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [blsa_pkg::APB_ADDR_W-1:0] paddr,
	input  wire logic [blsa_pkg::APB_DATA_W-1:0] pwdata,
	output logic      [blsa_pkg::APB_DATA_W-1:0] prdata,
	output logic                                 pready,
	output logic      [blsa_pkg::ITER_W-1:0]     iterations
);
	import blsa_pkg::*;

	logic              wr_en;
	logic [ITER_W-1:0] iter_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Register write; unknown addresses are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= ITER_RESET;
		end else if (wr_en && paddr == REG_ITERATIONS) begin
			iter_q <= pwdata[ITER_W-1:0];
		end
	end

	// Read decode.
	always_comb begin
		unique case (paddr)
			REG_ITERATIONS: prdata = APB_DATA_W'(iter_q);
			default:        prdata = '0;
		endcase
	end

	assign iterations = iter_q;

endmodule

`default_nettype wire

// ===== rtl/blsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// blsa_ctrl: sequencer of the logarithm unit
// Steps one item through normalization, the shift-add steps and the result
// hand-off, and drives the item handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module blsa_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	input  wire logic [blsa_pkg::ITER_W-1:0] iterations,
	input  wire logic                        special,
	output blsa_pkg::ctrl_t                  ctrl
);
	import blsa_pkg::*;

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] steps;

	// Step count saturates at the table size.
	assign steps = (iterations >= ITER_W'(TABLE_ENTRIES)) ?
		CNT_W'(TABLE_ENTRIES) : CNT_W'(iterations);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = special ? S_OUT : S_NORM;
			end
			S_NORM: begin
				if (cnt_q == CNT_W'(NORM_STEPS - 1))
					state_d = (steps == '0) ? S_FIN : S_STEP;
			end
			S_STEP: begin
				if (cnt_q == steps - CNT_W'(1)) state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and step counter; the counter restarts on every state change.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) cnt_q <= '0;
			else cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Outputs.
	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctrl      = '0;
		ctrl.idx  = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				ctrl.load = in_valid;
			end
			S_NORM: ctrl.norm = 1'b1;
			S_STEP: ctrl.step = 1'b1;
			S_FIN:  ctrl.fin  = 1'b1;
			S_OUT:  out_valid = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/blsa_dp.sv =====
// ----------------------------------------------------------------------------
// blsa_dp: datapath of the logarithm unit
// Normalizer by binary search, one shared shift-add-compare unit with the
// constant table, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module blsa_dp (
	input  wire logic                               clk,
	input  wire blsa_pkg::ctrl_t                    ctrl,
	input  wire logic signed [blsa_pkg::X_W-1:0]    x_value,
	output logic                                    special,
	output logic signed      [blsa_pkg::LOG_W-1:0]  log_value,
	output logic             [blsa_pkg::STAT_W-1:0] status
);
	import blsa_pkg::*;

	logic [MANT_W-1:0] z_q;
	logic [POS_W-1:0]  p_q;
	logic [MANT_W-1:0] xx_q;
	logic [YY_W-1:0]   yy_q;
	logic [LOG_W-1:0]  log_q;
	status_t           status_q;

	logic              x_neg;
	logic              x_zero;
	logic [SHIFT_W-1:0] norm_amt;
	logic              top_zero;
	logic [K_W-1:0]    k;
	logic [SHIFT_W-1:0] step_sh;
	logic [MANT_W:0]   zz;
	logic              take;
	logic [CHAR_W-1:0] charac;

	assign x_neg   = x_value[X_W-1];
	assign x_zero  = (x_value == '0);
	assign special = x_neg | x_zero;

	// Normalizer: test the top 32, 16, ... 1 bits and shift them out if clear.
	assign norm_amt = SHIFT_W'(1 << (NORM_STEPS - 1)) >> ctrl.idx;
	assign top_zero = ((z_q >> (SHIFT_W'(MANT_W) - norm_amt)) == '0);

	// Shared shift-add unit and compare against the mantissa.
	assign k       = ctrl.idx[K_W-1:0];
	assign step_sh = SHIFT_W'(k) + SHIFT_W'(1);
	assign zz      = {1'b0, xx_q} + {1'b0, (xx_q >> step_sh)};
	assign take    = (zz < {1'b0, z_q});

	// Characteristic: leading-one position less the input fraction bits.
	assign charac = CHAR_W'(p_q) - CHAR_W'(IN_FRAC);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			z_q      <= x_value[MANT_W-1:0];
			p_q      <= POS_W'(MANT_POS);
			xx_q     <= MANT_W'(1) << MANT_POS;
			yy_q     <= '0;
			log_q    <= '0;
			status_q <= x_neg ? STAT_UNDEF : (x_zero ? STAT_NEG_INF : STAT_OK);
		end
		if (ctrl.norm && top_zero) begin
			z_q <= z_q << norm_amt;
			p_q <= p_q - POS_W'(norm_amt);
		end
		if (ctrl.step && take) begin
			xx_q <= zz[MANT_W-1:0];
			yy_q <= yy_q + YY_W'(LOG_TABLE[k]);
		end
		if (ctrl.fin) begin
			log_q <= {charac, {FRAC_BITS{1'b0}}} + LOG_W'(yy_q);
		end
	end

	assign log_value = log_q;
	assign status    = status_q;

endmodule

`default_nettype wire
